@@ design/rth_pkg.sv @@
// ----------------------------------------------------------------------------
// rth_pkg
// Shared types, constants and the long division step for the RGB to HSV
// conversion pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

	// hue scale in sixteenths of a degree
	localparam int HUE_SECTOR     = 960;
	localparam int HUE_GREEN_BASE = 1920;
	localparam int HUE_BLUE_BASE  = 3840;
	localparam int HUE_FULL_TURN  = 5760;

	// divider geometry: 18-bit numerator, 8-bit divisor, 10 quotient bits
	localparam int DIV_D_W      = 8;
	localparam int DIV_Q_W      = 10;
	localparam int DIV_NUM_W    = DIV_D_W + DIV_Q_W;
	localparam int DIV_STEPS    = 2;
	localparam int DIV_STAGES   = DIV_Q_W / DIV_STEPS;

	localparam int HUE_W = 13;

	// input transfer
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	// result transfer
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [7:0]       saturation;
		logic [7:0]       brightness;
		logic [7:0]       opacity;
	} hsv_t;

	// partial state of one restoring divider
	typedef struct packed {
		logic [DIV_D_W-1:0] rem;
		logic [DIV_Q_W-1:0] work;
		logic [DIV_D_W-1:0] den;
	} div_t;

	// per-pixel data carried beside the dividers
	typedef struct packed {
		logic             neg;
		logic             gray;
		logic [HUE_W-1:0] base;
		logic [7:0]       brightness;
		logic [7:0]       opacity;
	} side_t;

	// one restoring step: shift in the next numerator bit, shift out a quotient bit
	function automatic div_t div_step(div_t d);
		logic [DIV_D_W:0] r_ext;
		logic [DIV_D_W:0] r_sub;
		div_t             o;
		r_ext = {d.rem, d.work[DIV_Q_W-1]};
		r_sub = r_ext - {1'b0, d.den};
		o     = d;
		if (r_ext >= {1'b0, d.den}) begin
			o.rem  = r_sub[DIV_D_W-1:0];
			o.work = {d.work[DIV_Q_W-2:0], 1'b1};
		end else begin
			o.rem  = r_ext[DIV_D_W-1:0];
			o.work = {d.work[DIV_Q_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

@@ design/rth_front.sv @@
// ----------------------------------------------------------------------------
// rth_front
// First stage: largest and smallest channel, spread, hue sector selection and
// the scaled numerators that seed both dividers.
// ----------------------------------------------------------------------------
module rth_front import rth_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   vld,
	input  pixel_t pix,
	output logic   vld_s1,
	output div_t   hue_s1,
	output div_t   sat_s1,
	output side_t  side_s1
);

	logic [7:0]           mx;
	logic [7:0]           mn;
	logic [7:0]           spread;
	logic signed [8:0]    diff;
	logic [7:0]           mag;
	logic [HUE_W-1:0]     base;
	logic [DIV_NUM_W-1:0] hue_num;
	logic [DIV_NUM_W-1:0] sat_num;

	// extremes of the three colour channels
	always_comb begin
		mx = pix.red;
		mn = pix.red;
		if (pix.green > mx) mx = pix.green;
		if (pix.blue > mx)  mx = pix.blue;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn)  mn = pix.blue;
		spread = mx - mn;
	end

	// sector choice, red wins ties then green
	always_comb begin
		if (pix.red == mx) begin
			diff = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
			base = '0;
		end else if (pix.green == mx) begin
			diff = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
			base = HUE_W'(HUE_GREEN_BASE);
		end else begin
			diff = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
			base = HUE_W'(HUE_BLUE_BASE);
		end
		mag = diff[8] ? 8'(-diff) : 8'(diff);
	end

	// numerators: 960 * |diff| and 255 * spread, both as shift and subtract
	always_comb begin
		hue_num = ({10'd0, mag} << 10) - ({10'd0, mag} << 6);
		sat_num = ({10'd0, spread} << 8) - {10'd0, spread};
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		hue_s1.rem          <= hue_num[DIV_NUM_W-1:DIV_Q_W];
		hue_s1.work         <= hue_num[DIV_Q_W-1:0];
		hue_s1.den          <= spread;
		sat_s1.rem          <= sat_num[DIV_NUM_W-1:DIV_Q_W];
		sat_s1.work         <= sat_num[DIV_Q_W-1:0];
		sat_s1.den          <= mx;
		side_s1.neg         <= diff[8];
		side_s1.gray        <= (spread == 8'd0);
		side_s1.base        <= base;
		side_s1.brightness  <= mx;
		side_s1.opacity     <= pix.alpha;
	end

endmodule

@@ design/rth_div_stage.sv @@
// ----------------------------------------------------------------------------
// rth_div_stage
// One pipeline stage of the hue and saturation dividers: two restoring
// steps on each, with the side data carried along.
// ----------------------------------------------------------------------------
module rth_div_stage import rth_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld,
	input  div_t  hue_d,
	input  div_t  sat_d,
	input  side_t side,
	output logic  vld_sn,
	output div_t  hue_sn,
	output div_t  sat_sn,
	output side_t side_sn
);

	div_t hue_nx;
	div_t sat_nx;

	// two quotient bits per stage
	always_comb begin
		hue_nx = hue_d;
		sat_nx = sat_d;
		for (int i = 0; i < DIV_STEPS; i++) begin
			hue_nx = div_step(hue_nx);
			sat_nx = div_step(sat_nx);
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else begin
			vld_sn <= vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		hue_sn  <= hue_nx;
		sat_sn  <= sat_nx;
		side_sn <= side;
	end

endmodule

@@ design/rth_back.sv @@
// ----------------------------------------------------------------------------
// rth_back
// Last stage: floor correction for negative hue offsets, sector base,
// wrap into one full turn and gray masking.
// ----------------------------------------------------------------------------
module rth_back import rth_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld,
	input  div_t  hue_d,
	input  div_t  sat_d,
	input  side_t side,
	output logic  vld_s7,
	output hsv_t  res_s7
);

	logic [13:0]        mag;
	logic signed [13:0] off;
	logic signed [13:0] sum;
	logic [HUE_W-1:0]   hue;

	// floor of a negative quotient rounds the magnitude up
	always_comb begin
		mag = {4'd0, hue_d.work};
		if (side.neg && (hue_d.rem != '0)) mag = mag + 14'd1;
		off = side.neg ? -$signed(mag) : $signed(mag);
		sum = $signed({1'b0, side.base}) + off;
		if (sum < 0) sum = sum + 14'(HUE_FULL_TURN);
		hue = side.gray ? '0 : sum[HUE_W-1:0];
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		res_s7.hue        <= hue;
		res_s7.saturation <= side.gray ? 8'd0 : sat_d.work[7:0];
		res_s7.brightness <= side.brightness;
		res_s7.opacity    <= side.opacity;
	end

endmodule

@@ design/rgb_to_hsv_convert.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// RGBA to HSV plus alpha, fully pipelined with two divider lanes.
// ----------------------------------------------------------------------------
// usage
//   input: a pixel is transferred on a rising edge with start high and busy
//   low. busy is always low, so a pixel may be offered on every clock.
//   output: each result is shown on result for exactly one cycle with done
//   high; the receiver takes it at the end of that cycle.
// pipeline
//   each pixel passes through registered stages in order: one front stage
//   (extremes, spread, numerators), five divider stages of two quotient
//   bits each, one correction stage.
// throughput
//   one pixel per clock; results leave in input order.
// reset
//   arst_n clears all valid bits at once; pixels in flight are dropped and
//   no result appears until a new pixel is accepted.
// stalls
//   the receiver cannot hold results off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert import rth_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  pixel_t pixel,
	output logic   done,
	output hsv_t   result
);

	logic  vld_p  [DIV_STAGES+1];
	div_t  hue_p  [DIV_STAGES+1];
	div_t  sat_p  [DIV_STAGES+1];
	side_t side_p [DIV_STAGES+1];

	// never blocks a transfer
	assign busy = 1'b0;

	// front stage
	rth_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start),
		.pix     (pixel),
		.vld_s1  (vld_p[0]),
		.hue_s1  (hue_p[0]),
		.sat_s1  (sat_p[0]),
		.side_s1 (side_p[0])
	);

	// divider stages
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		rth_div_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld     (vld_p[g]),
			.hue_d   (hue_p[g]),
			.sat_d   (sat_p[g]),
			.side    (side_p[g]),
			.vld_sn  (vld_p[g+1]),
			.hue_sn  (hue_p[g+1]),
			.sat_sn  (sat_p[g+1]),
			.side_sn (side_p[g+1])
		);
	end

	// correction and result register
	rth_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_p[DIV_STAGES]),
		.hue_d  (hue_p[DIV_STAGES]),
		.sat_d  (sat_p[DIV_STAGES]),
		.side   (side_p[DIV_STAGES]),
		.vld_s7 (done),
		.res_s7 (result)
	);

endmodule
